FILE: rtl/mvmac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the matrix-vector multiply-accumulate unit.
// No dependencies.

package mvmac_pkg;

    // Stream payload widths
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned IN_DATA_W  = IDX_W + VAL_W;
    localparam int unsigned SUM_W      = 64;
    localparam int unsigned OUT_DATA_W = 2 * SUM_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 21;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned COLS_CFG_W = 9;
    localparam int unsigned ROWS_CFG_W = 21;
    localparam int unsigned ROW_POS_W  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

    // Precision modes
    localparam logic [MODE_W-1:0] MODE_W32   = 2'd0;  // 32-bit wrap
    localparam logic [MODE_W-1:0] MODE_32X32 = 2'd1;  // 32x32 into 64
    localparam logic [MODE_W-1:0] MODE_W64   = 2'd2;  // 64-bit wrap
    localparam logic [MODE_W-1:0] MODE_64X64 = 2'd3;  // 64x64 into 128

    // Input command kinds
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    localparam logic [ROWS_CFG_W-1:0] ROW_LIMIT = 21'h100000;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0]     MODE_RST = MODE_32X32;
    localparam logic [COLS_CFG_W-1:0] COLS_RST = 9'd256;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 21'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ACC
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/matrix_vector_multiply_accumulate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Matrix-vector multiply-accumulate unit: vector store, shared 32x32 multiplier,
// row accumulator and output register. Depends on mvmac_pkg.
//
// Usage:
//   Slave stream: tuser is the command (0 load vector element, 1 matrix element),
//   tdata holds element_index [7:0] and element_value [71:8]. Load the vector
//   first by index, then stream the matrix in row-major order.
//   Master stream: one request per finished row, tdata holds row_sum_low [63:0]
//   and row_sum_high [127:64], tlast flags the last configured row.
//   Config port: write enable, register index (0 precision_mode, 1 column_count,
//   2 row_count) and data; write only while the unit is idle.
// Flow: a load writes the vector store when accepted.
//   A matrix element goes through accept and vector store read, four partial
//   products on the one 32x32 multiplier, a product sum and the accumulate; no
//   new request is accepted before that accumulate. A row sum shows on the
//   master side the cycle after the accumulate of its last element.
// Reset: configuration returns to mode 1, 256 columns, 1 row; accumulator and
//   positions clear. Vector store contents are undefined until loaded.
// Stall: the output register holds a result until taken; a matrix element that
//   reaches its accumulate step while the register is still full waits there,
//   and no new request is accepted until the register frees.

module matrix_vector_multiply_accumulate_unit #(
    parameter int unsigned MAX_COLUMNS = 256
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Slave stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: element_index [7:0], element_value [71:8]
    input  wire  [mvmac_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: command [0]
    input  wire                               i_s_axis_tuser,
    // Master stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // tdata: row_sum_low [63:0], row_sum_high [127:64]
    output logic [mvmac_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // tlast: last configured row
    output logic                              o_m_axis_tlast,
    // Configuration write port
    input  wire                               i_cfg_wr_en,
    input  wire  [mvmac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [mvmac_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mvmac_pkg::*;

    localparam int unsigned COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned CMP_W  = ((CNT_W > COLS_CFG_W) ? CNT_W : COLS_CFG_W) + 1;
    localparam int unsigned XIDX_W = COL_W + IDX_W;

    // Configuration registers
    logic [MODE_W-1:0]     r_mode;
    logic [COLS_CFG_W-1:0] r_cols_cfg;
    logic [ROWS_CFG_W-1:0] r_rows_cfg;

    // Control state
    t_state                r_state, n_state;
    logic [1:0]            r_step;
    logic [1:0]            r_pp_sh;
    logic [COL_W-1:0]      r_col;
    logic [ROW_POS_W-1:0]  r_row;
    logic [2*SUM_W-1:0]    r_acc;
    logic                  r_out_vld;

    // Datapath
    logic [VAL_W-1:0]      r_mem [MAX_COLUMNS];
    logic [VAL_W-1:0]      r_rd;
    logic [VAL_W-1:0]      r_val;
    logic [63:0]           r_pp;
    logic [2*SUM_W-1:0]    r_prod;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    // Handshake and control strobes
    logic                  w_in_acc;
    logic                  w_is_load;
    logic                  w_is_mat;
    logic                  w_out_free;
    logic                  w_prod_clr;
    logic                  w_prod_add;
    logic                  w_acc_go;

    // Request payload
    logic [IDX_W-1:0]      w_in_idx;
    logic [VAL_W-1:0]      w_in_val;
    logic [XIDX_W-1:0]     w_idx_ext;
    logic                  w_idx_ok;

    // Multiplier operands
    logic                  w_wide;
    logic [VAL_W-1:0]      w_opa;
    logic [VAL_W-1:0]      w_opb;
    logic [31:0]           w_mul_a;
    logic [31:0]           w_mul_b;
    logic [2*SUM_W-1:0]    w_pp_shifted;

    // Accumulate and position logic
    logic [2*SUM_W-1:0]    w_acc_sum;
    logic [2*SUM_W-1:0]    w_acc_new;
    logic [CMP_W-1:0]      w_cols_eff;
    logic [CMP_W-1:0]      w_col_next;
    logic                  w_row_done;
    logic [ROWS_CFG_W-1:0] w_rows_eff;
    logic [ROWS_CFG_W-1:0] w_row_next;
    logic                  w_last;

    assign w_in_idx  = i_s_axis_tdata[IDX_W-1:0];
    assign w_in_val  = i_s_axis_tdata[IN_DATA_W-1:IDX_W];
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_load = w_in_acc && (i_s_axis_tuser == CMD_LOAD);
    assign w_is_mat  = w_in_acc && (i_s_axis_tuser == CMD_MATRIX);
    assign w_idx_ext = XIDX_W'(w_in_idx);
    assign w_idx_ok  = (w_idx_ext < XIDX_W'(MAX_COLUMNS));
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RST;
            r_cols_cfg <= COLS_RST;
            r_rows_cfg <= ROWS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_PRECISION: r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_COLUMNS:   r_cols_cfg <= i_cfg_data[COLS_CFG_W-1:0];
                CFG_ROWS:      r_rows_cfg <= i_cfg_data[ROWS_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_is_mat) n_state = ST_MUL;
            ST_MUL:  if (r_step == 2'd3) n_state = ST_SUM;
            ST_SUM:  n_state = ST_ACC;
            ST_ACC:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_prod_clr      = 1'b0;
        w_prod_add      = 1'b0;
        w_acc_go        = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_MUL: begin
                w_prod_clr = (r_step == 2'd0);
                w_prod_add = (r_step != 2'd0);
            end
            ST_SUM:  w_prod_add = 1'b1;
            ST_ACC:  w_acc_go   = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == ST_MUL) ? r_step + 2'd1 : 2'd0;
        end
    end

    // Vector store: write on load, read the current column on a matrix request
    always_ff @(posedge i_clk) begin
        if (w_is_load && w_idx_ok) begin
            r_mem[w_idx_ext[COL_W-1:0]] <= w_in_val;
        end
        if (w_is_mat) begin
            r_rd  <= r_mem[r_col];
            r_val <= w_in_val;
        end
    end

    // Narrow modes use the low 32 bits of both operands
    assign w_wide  = (r_mode == MODE_W64) || (r_mode == MODE_64X64);
    assign w_opa   = w_wide ? r_val : {32'd0, r_val[31:0]};
    assign w_opb   = w_wide ? r_rd  : {32'd0, r_rd[31:0]};
    assign w_mul_a = r_step[1] ? w_opa[63:32] : w_opa[31:0];
    assign w_mul_b = r_step[0] ? w_opb[63:32] : w_opb[31:0];

    // Shared multiplier, one partial product per step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_pp    <= w_mul_a * w_mul_b;
            r_pp_sh <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
        end
    end

    // Place a partial product at its weight
    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_shifted = {64'd0, r_pp};
            2'd1:    w_pp_shifted = {32'd0, r_pp, 32'd0};
            default: w_pp_shifted = {r_pp, 64'd0};
        endcase
    end

    // Product sum
    always_ff @(posedge i_clk) begin
        if (w_prod_clr) begin
            r_prod <= '0;
        end else if (w_prod_add) begin
            r_prod <= r_prod + w_pp_shifted;
        end
    end

    // Accumulate with the wrap width of the current mode
    assign w_acc_sum = r_acc + r_prod;
    always_comb begin
        case (r_mode)
            MODE_64X64: w_acc_new = w_acc_sum;
            MODE_W32:   w_acc_new = {96'd0, w_acc_sum[31:0]};
            default:    w_acc_new = {64'd0, w_acc_sum[63:0]};
        endcase
    end

    // Effective column count: zero reads as one, saturates at the store depth
    always_comb begin
        if (r_cols_cfg == '0) begin
            w_cols_eff = CMP_W'(1);
        end else if (CMP_W'(r_cols_cfg) > CMP_W'(MAX_COLUMNS)) begin
            w_cols_eff = CMP_W'(MAX_COLUMNS);
        end else begin
            w_cols_eff = CMP_W'(r_cols_cfg);
        end
    end
    assign w_col_next = CMP_W'(r_col) + CMP_W'(1);
    assign w_row_done = !(w_col_next < w_cols_eff);

    // Effective row count: zero reads as one, saturates at the row limit
    always_comb begin
        if (r_rows_cfg == '0) begin
            w_rows_eff = ROWS_CFG_W'(1);
        end else if (r_rows_cfg > ROW_LIMIT) begin
            w_rows_eff = ROW_LIMIT;
        end else begin
            w_rows_eff = r_rows_cfg;
        end
    end
    assign w_row_next = ROWS_CFG_W'(r_row) + ROWS_CFG_W'(1);
    assign w_last     = (w_row_next >= w_rows_eff);

    // Accumulator and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc_go) begin
            if (w_row_done) begin
                r_acc <= '0;
                r_col <= '0;
                r_row <= w_last ? '0 : w_row_next[ROW_POS_W-1:0];
            end else begin
                r_acc <= w_acc_new;
                r_col <= w_col_next[COL_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_acc_go && w_row_done) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_go && w_row_done) begin
            r_out_data <= w_acc_new;
            r_out_last <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: sim/tb_matrix_vector_multiply_accumulate_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the matrix-vector multiply-accumulate unit: loads vector
// elements, streams matrix rows and checks every row sum against its own row predictor.
// Depends on mvmac_pkg and matrix_vector_multiply_accumulate_unit.

module tb_matrix_vector_multiply_accumulate_unit;
    import mvmac_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 24;
    localparam int unsigned RANDOM_ITEMS   = 430;
    localparam int unsigned QUIET_ITEMS    = 80;   // tail of the run without idling
    localparam int unsigned MAX_PRINTS     = 40;

    typedef struct packed {
        logic [SUM_W-1:0] sum_low;
        logic [SUM_W-1:0] sum_high;
        logic             last_row;
    } t_row_sum;

    // Row predictor and checker: mirrors config, vector store, accumulator and positions
    class t_row_sum_scoreboard;
        localparam int unsigned COL_LIMIT = 256;

        logic [MODE_W-1:0]     mode;
        logic [COLS_CFG_W-1:0] cols_reg;
        logic [ROWS_CFG_W-1:0] rows_reg;
        bit   [VAL_W-1:0]      vector_copy [COL_LIMIT];
        bit                    vector_valid [COL_LIMIT];
        bit   [127:0]          row_sum;
        int unsigned           col_pos;
        int unsigned           row_pos;
        t_row_sum              expected_rows [$];
        int unsigned           errors;
        int unsigned           loads;
        int unsigned           elements;
        int unsigned           rows_seen;

        function new();
            mode     = MODE_RST;
            cols_reg = COLS_RST;
            rows_reg = ROWS_RST;
            row_sum  = '0;
            col_pos  = 0;
            row_pos  = 0;
            foreach (vector_valid[i]) vector_valid[i] = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PRECISION: mode = data[MODE_W-1:0];
                CFG_COLUMNS:   cols_reg = data[COLS_CFG_W-1:0];
                CFG_ROWS:      rows_reg = data[ROWS_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction

        task report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("error: row sum %0d %s: got %h, expected %h", rows_seen, what, got, want);
        endtask

        // Accepted request: loads update the store, matrix elements accumulate
        function void accept_request(logic cmd, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
            bit [VAL_W-1:0] operand;
            bit [63:0]      prod64;
            bit [127:0]     prod128;
            bit [31:0]      sum32;
            bit [63:0]      sum64;
            int unsigned    cols_eff;
            int unsigned    rows_eff;
            t_row_sum       res;

            if (cmd == CMD_LOAD) begin
                vector_copy[idx]  = val;
                vector_valid[idx] = 1'b1;
                loads++;
                return;
            end
            elements++;
            operand = vector_copy[col_pos[IDX_W-1:0]];

            // The current mode truncates the running sum after each add
            case (mode)
                MODE_W32: begin
                    prod64  = {32'd0, val[31:0]} * {32'd0, operand[31:0]};
                    sum32   = row_sum[31:0] + prod64[31:0];
                    row_sum = {96'd0, sum32};
                end
                MODE_32X32: begin
                    prod64  = {32'd0, val[31:0]} * {32'd0, operand[31:0]};
                    sum64   = row_sum[63:0] + prod64;
                    row_sum = {64'd0, sum64};
                end
                MODE_W64: begin
                    prod64  = val * operand;
                    sum64   = row_sum[63:0] + prod64;
                    row_sum = {64'd0, sum64};
                end
                default: begin
                    prod128 = {64'd0, val} * {64'd0, operand};
                    row_sum = row_sum + prod128;
                end
            endcase

            cols_eff = (cols_reg == 0) ? 1 : ((cols_reg > COL_LIMIT) ? COL_LIMIT : cols_reg);
            if (col_pos + 1 < cols_eff) begin
                col_pos++;
                return;
            end

            // Row done: zero and oversized row counts clamp, last row wraps the position
            rows_eff = (rows_reg == 0) ? 1 : ((rows_reg > ROW_LIMIT) ? ROW_LIMIT : rows_reg);
            res.sum_low  = row_sum[63:0];
            res.sum_high = row_sum[127:64];
            res.last_row = (row_pos + 1 >= rows_eff);
            expected_rows.push_back(res);
            row_sum = '0;
            col_pos = 0;
            row_pos = res.last_row ? 0 : row_pos + 1;
        endfunction

        task check_row_sum(logic [SUM_W-1:0] low, logic [SUM_W-1:0] high, logic last);
            t_row_sum want;

            if (expected_rows.size() == 0) begin
                report("arrived with none expected, low", low, '0);
                return;
            end
            want = expected_rows.pop_front();
            if (low !== want.sum_low)
                report("row_sum_low", low, want.sum_low);
            if (high !== want.sum_high)
                report("row_sum_high", high, want.sum_high);
            if (last !== want.last_row)
                report("last_row", {63'd0, last}, {63'd0, want.last_row});
            rows_seen++;
        endtask
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = CMD_LOAD;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_PRECISION;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [OUT_DATA_W-1:0] m_tdata;
    wire                   m_tlast;

    t_row_sum_scoreboard board;
    bit                src_idle  = 1'b0;
    bit                sink_idle = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       settings = 0;

    matrix_vector_multiply_accumulate_unit #(
        .MAX_COLUMNS(256)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: tready drops in random-length bursts while sink idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_row_sum(m_tdata[SUM_W-1:0], m_tdata[OUT_DATA_W-1:SUM_W], m_tlast);
    end

    // Watchdog: too long without any accepted request on either stream
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request accepted for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [VAL_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2:       return {32'd0, $urandom};
            3:       return {$urandom, 32'hFFFF_FFFF};
            4:       return 64'h8000_0000_0000_0000 >> $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Drive one request and hold it until accepted; tvalid only drops for a gap
    task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val);
        int unsigned gap;

        if (src_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, idx};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        board.accept_request(cmd, idx, val);
    endtask

    // Matrix element; loads the operand first if that store entry was never written
    task automatic send_matrix_element(input logic [VAL_W-1:0] val);
        logic [IDX_W-1:0] pos;

        pos = board.col_pos[IDX_W-1:0];
        if (!board.vector_valid[pos])
            send_request(CMD_LOAD, pos, random_operand());
        send_request(CMD_MATRIX, IDX_W'($urandom), val);
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        board.write_register(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [COLS_CFG_W-1:0] cols,
                             input logic [ROWS_CFG_W-1:0] rows);
        write_register(CFG_PRECISION, CFG_DATA_W'(mode));
        write_register(CFG_COLUMNS, CFG_DATA_W'(cols));
        write_register(CFG_ROWS, CFG_DATA_W'(rows));
        settings++;
    endtask

    // One random setting: mostly short rows, sometimes the range extremes
    task automatic random_phase(input bit quiet);
        logic [MODE_W-1:0]     mode;
        logic [COLS_CFG_W-1:0] cols;
        logic [ROWS_CFG_W-1:0] rows;
        int unsigned           span;
        int unsigned           n;

        mode = MODE_W'($urandom_range(0, 3));
        case ($urandom_range(0, 19))
            0:       cols = 9'd0;
            1:       cols = 9'd511;
            2:       cols = 9'd256;
            3:       cols = COLS_CFG_W'($urandom_range(257, 511));
            4, 5:    cols = COLS_CFG_W'($urandom_range(9, 24));
            default: cols = COLS_CFG_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 15))
            0:          rows = '0;
            1:          rows = ROW_LIMIT;
            2:          rows = '1;
            3:          rows = ROWS_CFG_W'($urandom);
            4, 5, 6:    rows = 21'd1;
            default:    rows = ROWS_CFG_W'($urandom_range(2, 4));
        endcase

        wait_until_idle();
        src_idle  = !quiet && ($urandom_range(0, 3) != 0);
        sink_idle = !quiet && ($urandom_range(0, 3) != 0);
        configure(mode, cols, rows);

        // Refresh a few operands of the active columns
        span = (cols == 0) ? 1 : ((cols > 256) ? 256 : cols);
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 6))
                send_request(CMD_LOAD, IDX_W'($urandom_range(0, span - 1)), random_operand());

        n = $urandom_range(1, 30);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_request(CMD_LOAD, IDX_W'($urandom), random_operand());
            send_matrix_element(random_operand());
        end
    endtask

    initial begin
        int unsigned base;

        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting (32x32 into 64, 256 columns): three elements give no row sum
        send_request(CMD_LOAD, 8'd0, '1);
        send_request(CMD_LOAD, 8'd1, '1);
        send_request(CMD_LOAD, 8'd2, '0);
        send_request(CMD_LOAD, 8'd3, 64'hFFFF_FFFF_0000_0000);
        send_request(CMD_LOAD, 8'd255, 64'h0123_4567_89AB_CDEF);
        send_matrix_element('1);
        send_matrix_element('1);
        send_matrix_element(64'hDEAD_BEEF_FFFF_FFFF);
        // Column count shrinks mid-row: next element closes the row, flagged last
        wait_until_idle();
        write_register(CFG_COLUMNS, CFG_DATA_W'(9'd1));
        send_matrix_element('1);

        // Full 128-bit products with carry into the high word, two rows
        wait_until_idle();
        configure(MODE_64X64, 9'd2, 21'd2);
        repeat (4) send_matrix_element('1);

        // Zero column and row counts act as one
        wait_until_idle();
        configure(MODE_W32, 9'd0, 21'd0);
        send_matrix_element('1);

        // Mode change mid-row: 32-bit wrap then 64-bit wrap
        wait_until_idle();
        configure(MODE_W32, 9'd3, 21'd1);
        send_matrix_element('1);
        wait_until_idle();
        write_register(CFG_PRECISION, CFG_DATA_W'(MODE_W64));
        send_matrix_element('1);
        send_matrix_element(64'hFFFF_FFFF_FFFF_FFFE);

        // Mode change mid-row clears a nonzero high word
        wait_until_idle();
        configure(MODE_64X64, 9'd2, 21'd1);
        send_matrix_element('1);
        wait_until_idle();
        write_register(CFG_PRECISION, CFG_DATA_W'(MODE_32X32));
        send_matrix_element(64'd5);

        // Random settings, then a tail without idling
        base = board.loads + board.elements;
        while (board.loads + board.elements < base + RANDOM_ITEMS - QUIET_ITEMS)
            random_phase(1'b0);
        while (board.loads + board.elements < base + RANDOM_ITEMS)
            random_phase(1'b1);
        wait_until_idle();

        if (board.pending() != 0)
            board.report("still expected at end, count", SUM_W'(board.pending()), '0);
        $display("Run covered %0d vector loads and %0d matrix elements over %0d register settings,",
                 board.loads, board.elements, settings);
        $display("with %0d row sums checked and %0d mismatches.", board.rows_seen, board.errors);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/mvmac_pkg.sv
rtl/matrix_vector_multiply_accumulate_unit.sv
sim/tb_matrix_vector_multiply_accumulate_unit.sv
